>>> rtl/core/vvds_pkg.sv
// ============================================================================
// vvds_pkg
// Shared types, constants and helper tables for the regularised vortex
// velocity direct-sum block.
// ============================================================================
package vvds_pkg;

    // Default parameter values
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    // Fixed-point constants (Q30 unless stated)
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [31:0] E_INV        = 32'd395007542;
    localparam logic [31:0] INV_TWO_PI   = 32'd170891319;
    localparam int          EXP_CUT      = 32;
    localparam logic [3:0]  HORNER_TERMS = 4'd12;
    localparam logic [6:0]  TERM_DIV_ITERS = 7'd64;

    // Input item
    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic signed [31:0] circulation;
        logic        [30:0] core_radius;
        logic               last;
    } vvds_in_t;

    // Result item
    typedef struct packed {
        logic signed [31:0] vel_u;
        logic signed [31:0] vel_v;
        logic               saturated;
    } vvds_out_t;

    // Operand selection for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_UXX,
        MUL_UYY,
        MUL_CORE,
        MUL_EF,
        MUL_RECIP,
        MUL_QK,
        MUL_EINV,
        MUL_CG,
        MUL_WUY,
        MUL_WUX,
        MUL_SLO,
        MUL_SHI
    } mul_op_t;

    // Operand selection for the shared divider
    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_T,
        DIV_AX,
        DIV_AY
    } div_op_t;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_R2,
        S_CHK,
        S_TPRE,
        S_TDIV,
        S_TCHK,
        S_H1,
        S_H2,
        S_H3,
        S_H4,
        S_EXP,
        S_EXP2,
        S_CG,
        S_W,
        S_AX,
        S_AXW,
        S_AXACC,
        S_AYW,
        S_AYACC,
        S_SC1,
        S_SC2,
        S_SC3,
        S_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load_in;
        mul_op_t mul_op;
        div_op_t div_op;
        logic    r2_part;
        logic    r2_sum;
        logic    c2_load;
        logic    g_one;
        logic    t_load;
        logic    h_x;
        logic    h_q;
        logic    h_step;
        logic    exp_step;
        logic    g_exp;
        logic    w_load;
        logic    acc_x;
        logic    acc_y;
        logic    sc_hi;
        logic    sc_lo;
        logic    sc_fin;
        logic    out_load;
    } vvds_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic r2_gt_min;
        logic t_pre_over;
        logic t_over;
        logic div_busy;
        logic k_last;
        logic n_zero;
        logic last;
        logic axis;
        logic res_busy;
    } vvds_sts_t;

    // Truncated reciprocal floor((2^32 - 1) / k) for the series divisors.
    function automatic logic [31:0] horner_recip(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/vortex_velocity_direct_sum_top.sv
// ============================================================================
// vortex_velocity_direct_sum_top
// Regularised Biot-Savart direct sum of source vortices at one target point.
// ============================================================================
//  Channel  Direction  Handshake              Payload
//  src      in         src_valid/src_ready    vvds_in_t  (target, source, last)
//  res      out        res_valid/res_ready    vvds_out_t (vel_u, vel_v, saturated)
//  cfg      in         cfg_we                 min_dist_sq, 16 bits
//
//  A skipped source ends at the distance check; one caught past the exponential
//  cut-off by the quick check skips the core-ratio division; one found past it
//  after the core-ratio division skips the series; one inside it runs the series
//  and n exponent steps, n being the integer part of r^2/core^2. The two 64-step
//  term divisions and the core-ratio division use the shared divider; the 12-step
//  series uses the shared multiplier. A source marked last adds output scaling,
//  held while res stalls. Reset clears the sums, the threshold and the controller;
//  no clearing pass. A new source is taken while a result waits; a second result
//  waits for the first transfer on res.
// ============================================================================
module vortex_velocity_direct_sum_top #(
    parameter int FRAC_BITS = vvds_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = vvds_pkg::ACC_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  vvds_pkg::vvds_in_t  src_data,
    output logic                res_valid,
    input  logic                res_ready,
    output vvds_pkg::vvds_out_t res_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data
);
    import vvds_pkg::*;

    vvds_cmd_t cmd;
    vvds_sts_t sts;

    // Sequencer
    vvds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    vvds_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_data  (src_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

>>> rtl/core/vvds_div.sv
// ============================================================================
// vvds_div
// Restoring divider shared by the core-ratio and velocity-term divisions.
// One quotient bit per cycle; the partial remainder may be preloaded.
// ============================================================================
module vvds_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rem_init,
    input  logic [63:0] dividend,
    input  logic [61:0] divisor,
    input  logic [6:0]  iters,
    output logic        busy,
    output logic [63:0] quot
);
    logic        busy_reg;
    logic        busy_next;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic [63:0] rem_reg;
    logic [63:0] rem_next;
    logic [63:0] dvd_reg;
    logic [61:0] dvs_reg;
    logic [63:0] quot_reg;
    logic [63:0] trial;
    logic        ge;

    // Trial subtraction for one quotient bit
    always_comb
    begin
        trial    = {rem_reg[62:0], dvd_reg[63]};
        ge       = (trial >= {2'b00, dvs_reg});
        rem_next = ge ? (trial - {2'b00, dvs_reg}) : trial;
    end

    // Iteration control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = iters;
        end
        else if (busy_reg)
        begin
            busy_next = (cnt_reg != 7'd1);
            cnt_next  = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Remainder, dividend and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[62:0], 1'b0};
            quot_reg <= {quot_reg[62:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while a division is in progress");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == 7'd0))
        else $error("divider idle with iterations outstanding");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == 7'd1) |=> !busy_reg)
        else $error("divider did not finish after its last iteration");
`endif

endmodule

>>> rtl/core/vvds_datapath.sv
// ============================================================================
// vvds_datapath
// Operand registers, shared multiplier, divider, series evaluation,
// saturating accumulators and the result register.
// ============================================================================
module vvds_datapath #(
    parameter int FRAC_BITS = vvds_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = vvds_pkg::ACC_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vvds_pkg::vvds_in_t  src_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  vvds_pkg::vvds_cmd_t cmd,
    output vvds_pkg::vvds_sts_t sts,
    output logic                res_valid,
    input  logic                res_ready,
    output vvds_pkg::vvds_out_t res_data
);
    import vvds_pkg::*;

    localparam int R2W    = 65 - FRAC_BITS;
    localparam int TQW    = FRAC_BITS + 7;
    localparam int PRE_SH = FRAC_BITS - 7;
    localparam logic [TQW-1:0] T_LIM   = TQW'(EXP_CUT) << FRAC_BITS;
    localparam logic [63:0]    LIM_POS = (64'd1 << (ACC_WIDTH - 1)) - 64'd1;
    localparam logic [63:0]    LIM_NEG = 64'd1 << (ACC_WIDTH - 1);
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = ACC_WIDTH'(LIM_POS);
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = ACC_WIDTH'(LIM_NEG);

    // Configuration and operand registers
    logic [15:0]           min_reg;
    logic [31:0]           ux_reg;
    logic [31:0]           uy_reg;
    logic                  rx_neg_reg;
    logic                  ry_neg_reg;
    logic                  circ_neg_reg;
    logic [31:0]           circ_mag_reg;
    logic [30:0]           core_reg;
    logic                  last_reg;
    logic [63:0]           prod_reg;
    logic [R2W-1:0]        r2_part_reg;
    logic [R2W-1:0]        r2q_reg;
    logic [61:0]           c2_reg;
    logic [5:0]            n_reg;
    logic [29:0]           f_reg;
    logic [30:0]           e_reg;
    logic [3:0]            k_reg;
    logic [30:0]           x_reg;
    logic [30:0]           qest_reg;
    logic [30:0]           g_reg;
    logic [31:0]           w_reg;
    logic signed [ACC_WIDTH-1:0] sum_ax_reg;
    logic signed [ACC_WIDTH-1:0] sum_ay_reg;
    logic [4:0]            hi_reg;
    logic [31:0]           plo_reg;
    logic [31:0]           u_reg;
    logic [31:0]           v_reg;
    logic                  sat_reg;
    logic                  axis_reg;
    logic                  res_valid_reg;
    vvds_out_t             res_data_reg;

    // Combinational nets
    logic signed [32:0]    rx_w;
    logic signed [32:0]    ry_w;
    logic [32:0]           ux_w;
    logic [32:0]           uy_w;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           prod_next;
    logic                  div_start;
    logic [63:0]           div_rem_init;
    logic [63:0]           div_dividend;
    logic [61:0]           div_divisor;
    logic [6:0]            div_iters;
    logic                  div_busy;
    logic [63:0]           div_quot;
    logic [63:0]           pre_rem;
    logic [TQW-1:0]        tq;
    logic [31:0]           h_rem;
    logic [30:0]           h_q;
    logic                  term_neg;
    logic [63:0]           term_lim;
    logic [63:0]           term_mag;
    logic signed [ACC_WIDTH-1:0] term;
    logic signed [ACC_WIDTH-1:0] acc_base;
    logic signed [ACC_WIDTH:0]   acc_wide;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic signed [ACC_WIDTH-1:0] sc_sum;
    logic [ACC_WIDTH-1:0]  sc_mag;
    logic [4:0]            hi_next;
    logic [33:0]           sc_p;
    logic                  sc_sat;
    logic [31:0]           sc_val;

    // Offsets and magnitudes of the incoming item
    always_comb
    begin
        rx_w = {src_data.target_x[31], src_data.target_x}
             - {src_data.src_x[31], src_data.src_x};
        ry_w = {src_data.target_y[31], src_data.target_y}
             - {src_data.src_y[31], src_data.src_y};
        ux_w = rx_w[32] ? 33'(-rx_w) : 33'(rx_w);
        uy_w = ry_w[32] ? 33'(-ry_w) : 33'(ry_w);
    end

    // Shared multiplier operand selection
    always_comb
    begin
        case (cmd.mul_op)
            MUL_UXX:   begin mul_a = ux_reg;                mul_b = ux_reg;                 end
            MUL_UYY:   begin mul_a = uy_reg;                mul_b = uy_reg;                 end
            MUL_CORE:  begin mul_a = {1'b0, core_reg};      mul_b = {1'b0, core_reg};       end
            MUL_EF:    begin mul_a = {1'b0, e_reg};         mul_b = {2'b00, f_reg};         end
            MUL_RECIP: begin mul_a = {1'b0, prod_reg[60:30]}; mul_b = horner_recip(k_reg);  end
            MUL_QK:    begin mul_a = prod_reg[63:32];       mul_b = {28'd0, k_reg};         end
            MUL_EINV:  begin mul_a = {1'b0, e_reg};         mul_b = E_INV;                  end
            MUL_CG:    begin mul_a = circ_mag_reg;          mul_b = {1'b0, g_reg};          end
            MUL_WUY:   begin mul_a = prod_reg[61:30];       mul_b = uy_reg;                 end
            MUL_WUX:   begin mul_a = w_reg;                 mul_b = ux_reg;                 end
            MUL_SLO:   begin mul_a = {2'b00, sc_mag[29:0]}; mul_b = INV_TWO_PI;             end
            MUL_SHI:   begin mul_a = {27'd0, hi_reg};       mul_b = INV_TWO_PI;             end
            default:   begin mul_a = '0;                    mul_b = '0;                     end
        endcase
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    // Divider operand selection
    assign pre_rem = 64'(r2q_reg) << PRE_SH;

    always_comb
    begin
        div_start = (cmd.div_op != DIV_NONE);
        case (cmd.div_op)
            DIV_T:
            begin
                div_rem_init = pre_rem;
                div_dividend = '0;
                div_divisor  = c2_reg;
                div_iters    = 7'(TQW);
            end
            DIV_AX, DIV_AY:
            begin
                div_rem_init = '0;
                div_dividend = prod_reg;
                div_divisor  = 62'(r2q_reg);
                div_iters    = TERM_DIV_ITERS;
            end
            default:
            begin
                div_rem_init = '0;
                div_dividend = '0;
                div_divisor  = '0;
                div_iters    = '0;
            end
        endcase
    end

    vvds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    assign tq = div_quot[TQW-1:0];

    // One series step: quotient by the term index with reciprocal correction
    always_comb
    begin
        h_rem = {1'b0, x_reg} - prod_reg[31:0];
        h_q   = qest_reg + 31'((h_rem >= {28'd0, k_reg}) ? 1 : 0);
    end

    // Clamped, signed velocity term and saturating accumulation
    always_comb
    begin
        term_neg = cmd.acc_y ? (circ_neg_reg != rx_neg_reg)
                             : (circ_neg_reg == ry_neg_reg);
        term_lim = term_neg ? LIM_NEG : LIM_POS;
        term_mag = (div_quot > term_lim) ? term_lim : div_quot;
        term     = term_neg ? -ACC_WIDTH'(term_mag) : ACC_WIDTH'(term_mag);
        acc_base = cmd.acc_y ? sum_ay_reg : sum_ax_reg;
        acc_wide = {acc_base[ACC_WIDTH-1], acc_base} + {term[ACC_WIDTH-1], term};
        if (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1])
        begin
            acc_next = acc_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = acc_wide[ACC_WIDTH-1:0];
        end
    end

    // Output scaling by 1/(2 pi) with clipping to 32 bits
    always_comb
    begin
        sc_sum  = axis_reg ? sum_ay_reg : sum_ax_reg;
        sc_mag  = sc_sum[ACC_WIDTH-1] ? ACC_WIDTH'(-sc_sum) : ACC_WIDTH'(sc_sum);
        hi_next = (sc_mag[ACC_WIDTH-1:30] >= (ACC_WIDTH-30)'(16)) ? 5'd16 : sc_mag[34:30];
        sc_p    = {2'b00, plo_reg} + {2'b00, prod_reg[31:0]};
        if (sc_sum[ACC_WIDTH-1])
        begin
            sc_sat = (sc_p > 34'h0_8000_0000);
            sc_val = sc_sat ? 32'h8000_0000 : -sc_p[31:0];
        end
        else
        begin
            sc_sat = (sc_p > 34'h0_7FFF_FFFF);
            sc_val = sc_sat ? 32'h7FFF_FFFF : sc_p[31:0];
        end
    end

    // Control-state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= '0;
            sum_ax_reg    <= '0;
            sum_ay_reg    <= '0;
            axis_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_reg <= cfg_data;
            end
            if (cmd.load_in)
            begin
                axis_reg <= 1'b0;
            end
            else if (cmd.sc_fin)
            begin
                axis_reg <= ~axis_reg;
            end
            if (cmd.out_load)
            begin
                sum_ax_reg <= '0;
                sum_ay_reg <= '0;
            end
            else if (cmd.acc_x)
            begin
                sum_ax_reg <= acc_next;
            end
            else if (cmd.acc_y)
            begin
                sum_ay_reg <= acc_next;
            end
            if (cmd.out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ux_reg       <= ux_w[31:0];
            uy_reg       <= uy_w[31:0];
            rx_neg_reg   <= rx_w[32];
            ry_neg_reg   <= ry_w[32];
            circ_neg_reg <= src_data.circulation[31];
            circ_mag_reg <= src_data.circulation[31] ? 32'(-src_data.circulation)
                                                     : 32'(src_data.circulation);
            core_reg     <= src_data.core_radius;
            last_reg     <= src_data.last;
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.r2_part)
        begin
            r2_part_reg <= R2W'(prod_reg >> FRAC_BITS);
        end
        if (cmd.r2_sum)
        begin
            r2q_reg <= r2_part_reg + R2W'(prod_reg >> FRAC_BITS);
        end
        if (cmd.c2_load)
        begin
            c2_reg <= prod_reg[61:0];
        end
        // Series set-up from the core ratio
        if (cmd.t_load)
        begin
            n_reg <= tq[FRAC_BITS+5:FRAC_BITS];
            f_reg <= 30'(tq[FRAC_BITS-1:0]) << (30 - FRAC_BITS);
            e_reg <= Q30_ONE;
            k_reg <= HORNER_TERMS;
        end
        else if (cmd.h_step)
        begin
            e_reg <= Q30_ONE - h_q;
            k_reg <= k_reg - 4'd1;
        end
        else if (cmd.exp_step)
        begin
            e_reg <= prod_reg[60:30];
            n_reg <= n_reg - 6'd1;
        end
        if (cmd.h_x)
        begin
            x_reg <= prod_reg[60:30];
        end
        if (cmd.h_q)
        begin
            qest_reg <= prod_reg[62:32];
        end
        if (cmd.g_one)
        begin
            g_reg <= Q30_ONE;
        end
        else if (cmd.g_exp)
        begin
            g_reg <= Q30_ONE - e_reg;
        end
        if (cmd.w_load)
        begin
            w_reg <= prod_reg[61:30];
        end
        // Output scaling pipeline
        if (cmd.sc_hi)
        begin
            hi_reg <= hi_next;
        end
        if (cmd.sc_lo)
        begin
            plo_reg <= 32'(prod_reg >> 30);
        end
        if (cmd.sc_fin)
        begin
            if (axis_reg)
            begin
                v_reg   <= sc_val;
                sat_reg <= sat_reg | sc_sat;
            end
            else
            begin
                u_reg   <= sc_val;
                sat_reg <= sc_sat;
            end
        end
        if (cmd.out_load)
        begin
            res_data_reg.vel_u     <= u_reg;
            res_data_reg.vel_v     <= v_reg;
            res_data_reg.saturated <= sat_reg;
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.r2_gt_min  = (r2q_reg > R2W'(min_reg));
        sts.t_pre_over = (pre_rem >= {2'b00, c2_reg});
        sts.t_over     = (tq > T_LIM);
        sts.div_busy   = div_busy;
        sts.k_last     = (k_reg == 4'd1);
        sts.n_zero     = (n_reg == 6'd0);
        sts.last       = last_reg;
        sts.axis       = axis_reg;
        sts.res_busy   = res_valid_reg & ~res_ready;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

>>> rtl/core/vvds_ctrl.sv
// ============================================================================
// vvds_ctrl
// Sequencing state machine: steps one source through squaring, core ratio,
// exponential, velocity terms, accumulation and output scaling.
// ============================================================================
module vvds_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  vvds_pkg::vvds_sts_t sts,
    output vvds_pkg::vvds_cmd_t cmd
);
    import vvds_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        cmd.div_op = DIV_NONE;
        src_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                src_ready = 1'b1;
                if (src_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SQX;
                end
            end
            S_SQX:
            begin
                cmd.mul_op = MUL_UXX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul_op  = MUL_UYY;
                cmd.r2_part = 1'b1;
                state_next  = S_R2;
            end
            S_R2:
            begin
                cmd.mul_op = MUL_CORE;
                cmd.r2_sum = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.c2_load = 1'b1;
                if (sts.r2_gt_min)
                begin
                    state_next = S_TPRE;
                end
                else
                begin
                    state_next = sts.last ? S_SC1 : S_IDLE;
                end
            end
            // Core ratio, or straight to full weight when far outside the core
            S_TPRE:
            begin
                if (sts.t_pre_over)
                begin
                    cmd.g_one  = 1'b1;
                    state_next = S_CG;
                end
                else
                begin
                    cmd.div_op = DIV_T;
                    state_next = S_TDIV;
                end
            end
            S_TDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                if (sts.t_over)
                begin
                    cmd.g_one  = 1'b1;
                    state_next = S_CG;
                end
                else
                begin
                    cmd.t_load = 1'b1;
                    state_next = S_H1;
                end
            end
            // Series for the fractional part of the exponent
            S_H1:
            begin
                cmd.mul_op = MUL_EF;
                state_next = S_H2;
            end
            S_H2:
            begin
                cmd.mul_op = MUL_RECIP;
                cmd.h_x    = 1'b1;
                state_next = S_H3;
            end
            S_H3:
            begin
                cmd.mul_op = MUL_QK;
                cmd.h_q    = 1'b1;
                state_next = S_H4;
            end
            S_H4:
            begin
                cmd.h_step = 1'b1;
                state_next = sts.k_last ? S_EXP : S_H1;
            end
            // Integer part of the exponent by repeated multiplication
            S_EXP:
            begin
                if (sts.n_zero)
                begin
                    cmd.g_exp  = 1'b1;
                    state_next = S_CG;
                end
                else
                begin
                    cmd.mul_op = MUL_EINV;
                    state_next = S_EXP2;
                end
            end
            S_EXP2:
            begin
                cmd.exp_step = 1'b1;
                state_next   = S_EXP;
            end
            // Weighted circulation and the two velocity terms
            S_CG:
            begin
                cmd.mul_op = MUL_CG;
                state_next = S_W;
            end
            S_W:
            begin
                cmd.mul_op = MUL_WUY;
                cmd.w_load = 1'b1;
                state_next = S_AX;
            end
            S_AX:
            begin
                cmd.div_op = DIV_AX;
                cmd.mul_op = MUL_WUX;
                state_next = S_AXW;
            end
            S_AXW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_AXACC;
                end
            end
            S_AXACC:
            begin
                cmd.acc_x  = 1'b1;
                cmd.div_op = DIV_AY;
                state_next = S_AYW;
            end
            S_AYW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_AYACC;
                end
            end
            S_AYACC:
            begin
                cmd.acc_y  = 1'b1;
                state_next = sts.last ? S_SC1 : S_IDLE;
            end
            // Output scaling, one axis per pass
            S_SC1:
            begin
                cmd.mul_op = MUL_SLO;
                cmd.sc_hi  = 1'b1;
                state_next = S_SC2;
            end
            S_SC2:
            begin
                cmd.mul_op = MUL_SHI;
                cmd.sc_lo  = 1'b1;
                state_next = S_SC3;
            end
            S_SC3:
            begin
                cmd.sc_fin = 1'b1;
                state_next = sts.axis ? S_OUT : S_SC1;
            end
            S_OUT:
            begin
                if (!sts.res_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> tb/tb_vortex_velocity_direct_sum_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_vortex_velocity_direct_sum_top
// Drives streams of source vortices into the direct-sum block, predicts the
// induced velocity of every target in fixed point and checks each result.
// ============================================================================
module tb_vortex_velocity_direct_sum_top;
    import vvds_pkg::*;

    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint Q30 = 64'd1073741824;
    localparam int WATCHDOG_LIMIT = 20000;

    // Scoreboard: predicts velocities from accepted sources and checks results
    class velocity_scoreboard;
        longint    sum_ax;
        longint    sum_ay;
        bit [15:0] min_dist;
        vvds_out_t pending_vel[$];
        int        n_errors;
        int        n_checked;

        function void clear_sums();
            sum_ax = 0;
            sum_ay = 0;
        endfunction

        function longint sat_add(longint a, longint b);
            if (b > 0 && a > ACC_HI - b) return ACC_HI;
            if (b < 0 && a < ACC_LO - b) return ACC_LO;
            return a + b;
        endfunction

        function longint signed_term(bit [63:0] m, bit neg);
            bit [63:0] lim;
            lim = neg ? 64'(ACC_HI) + 1 : 64'(ACC_HI);
            if (m > lim) m = lim;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // One minus exp(-r2/core^2) in Q30
        function bit [63:0] core_factor(bit [63:0] r2, bit [63:0] core);
            bit [63:0] c2, q, rem, tlim, n, f, e;
            c2 = core * core;
            tlim = 64'd32 << 16;
            if (c2 == 0) return Q30;
            q = r2 / c2;
            rem = r2 % c2;
            for (int i = 0; i < 32; i++)
            begin
                if (q > tlim) return Q30;
                q = q << 1;
                rem = rem << 1;
                if (rem >= c2)
                begin
                    rem -= c2;
                    q++;
                end
            end
            if (q > tlim) return Q30;
            n = q >> 16;
            f = (q & 64'hFFFF) << 14;
            e = Q30;
            for (int k = 12; k >= 1; k--)
                e = Q30 - ((e * f) >> 30) / k;
            for (bit [63:0] j = 0; j < n; j++)
                e = (e * 64'(E_INV)) >> 30;
            return Q30 - e;
        endfunction

        function longint scale_velocity(longint s, inout bit sat);
            bit [63:0] m, p;
            m = s < 0 ? -s : s;
            p = (m >> 30) * 64'(INV_TWO_PI) + (((m & (Q30 - 1)) * 64'(INV_TWO_PI)) >> 30);
            if (s < 0)
            begin
                if (p > 64'd2147483648)
                begin
                    sat = 1;
                    return -64'sd2147483648;
                end
                return -longint'(p);
            end
            if (p > 64'd2147483647)
            begin
                sat = 1;
                return 64'sd2147483647;
            end
            return longint'(p);
        endfunction

        // Notes an accepted source and queues a velocity on the last one
        function void note_source(vvds_in_t s);
            longint    rx, ry;
            bit [63:0] ux, uy, r2, g, w, tax, tay;
            bit        negw, sat;
            vvds_out_t vel;
            rx = longint'(s.target_x) - longint'(s.src_x);
            ry = longint'(s.target_y) - longint'(s.src_y);
            ux = rx < 0 ? -rx : rx;
            uy = ry < 0 ? -ry : ry;
            r2 = ((ux * ux) >> 16) + ((uy * uy) >> 16);
            if (r2 > 64'(min_dist))
            begin
                g = core_factor(r2, 64'(s.core_radius));
                w = (64'(s.circulation < 0 ? -longint'(s.circulation)
                                           : longint'(s.circulation)) * g) >> 30;
                negw = s.circulation < 0;
                tax = (w * uy) / r2;
                tay = (w * ux) / r2;
                sum_ax = sat_add(sum_ax, signed_term(tax, negw == (ry < 0)));
                sum_ay = sat_add(sum_ay, signed_term(tay, negw != (rx < 0)));
            end
            if (s.last)
            begin
                sat = 0;
                vel.vel_u = 32'(scale_velocity(sum_ax, sat));
                vel.vel_v = 32'(scale_velocity(sum_ay, sat));
                vel.saturated = sat;
                pending_vel.push_back(vel);
                clear_sums();
            end
        endfunction

        function void check_velocity(vvds_out_t got);
            vvds_out_t want;
            if (pending_vel.size() == 0)
            begin
                $error("unexpected result u=%0d v=%0d", got.vel_u, got.vel_v);
                n_errors++;
                return;
            end
            want = pending_vel.pop_front();
            n_checked++;
            if (got.vel_u !== want.vel_u)
            begin
                $error("vel_u expected %0d actual %0d", want.vel_u, got.vel_u);
                n_errors++;
            end
            if (got.vel_v !== want.vel_v)
            begin
                $error("vel_v expected %0d actual %0d", want.vel_v, got.vel_v);
                n_errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $error("saturated expected %0b actual %0b", want.saturated, got.saturated);
                n_errors++;
            end
        endfunction
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                src_valid = 0;
    logic                src_ready;
    vvds_in_t            src_data = '0;
    logic                res_valid;
    logic                res_ready = 0;
    vvds_out_t           res_data;
    logic                cfg_we = 0;
    logic [15:0]         cfg_data = '0;

    velocity_scoreboard  board;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  quiet_cycles;
    int                  n_sources;
    bit                  timed_out;

    vortex_velocity_direct_sum_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Receiver side: random stalls, check on every result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                board.check_velocity(res_data);
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((src_valid && src_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            timed_out = 1;
            $display("FAIL");
            $finish;
        end
    end

    // Offers one source and waits for its transfer; valid drops only while idling
    task automatic send_source(vvds_in_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            src_valid <= 0;
            @(posedge clk);
        end
        src_valid <= 1;
        src_data <= s;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        board.note_source(s);
        n_sources++;
    endtask

    task automatic drain_results();
        src_valid <= 0;
        while (board.pending_vel.size() != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
    endtask

    task automatic set_min_dist(bit [15:0] v);
        cfg_we <= 1;
        cfg_data <= v;
        board.min_dist = v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(400)) - 200);
            default: return 32'($signed($urandom_range(64 << 16)) - (32 << 16));
        endcase
    endfunction

    function automatic vvds_in_t rand_source(logic [31:0] tx, logic [31:0] ty, bit lst);
        vvds_in_t s;
        s.target_x = tx;
        s.target_y = ty;
        s.src_x = ($urandom_range(5) == 0) ? tx : rand_coord();
        s.src_y = ($urandom_range(5) == 0) ? ty : rand_coord();
        case ($urandom_range(4))
            0: s.circulation = $urandom;
            1: s.circulation = 0;
            default: s.circulation = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
        case ($urandom_range(4))
            0: s.core_radius = 31'($urandom);
            1: s.core_radius = 0;
            default: s.core_radius = 31'($urandom_range(1 << 17, 1));
        endcase
        s.last = lst;
        return s;
    endfunction

    // One target with a random number of sources
    task automatic send_target();
        logic [31:0] tx, ty;
        int          n;
        tx = rand_coord();
        ty = rand_coord();
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            send_source(rand_source(tx, ty, i == n - 1));
    endtask

    task automatic run_directed();
        vvds_in_t s;
        // Extremes of every field, single-source targets
        s = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1};
        send_source(s);
        s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 31'd0, 1'b1};
        send_source(s);
        // Coincident source: zero offset, skipped
        s = '{32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 31'h0001_0000, 1'b1};
        send_source(s);
        // Zero circulation
        s = '{32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 31'h0001_0000, 1'b1};
        send_source(s);
        // Inside the core, near the core, far beyond it
        s = '{32'h0000_4000, 32'h0000_2000, 32'd0, 32'd0, 32'h0003_0000, 31'h0001_0000, 1'b1};
        send_source(s);
        s = '{32'h0002_0000, 32'hFFFE_0000, 32'd0, 32'd0, 32'hFFFD_0000, 31'h0001_0000, 1'b1};
        send_source(s);
        s = '{32'h0040_0000, 32'd0, 32'd0, 32'd0, 32'h0010_0000, 31'h0000_0100, 1'b1};
        send_source(s);
        // Zero core radius: point vortex
        s = '{32'h0000_8000, 32'h0000_8000, 32'd0, 32'd0, 32'h0001_0000, 31'd0, 1'b1};
        send_source(s);
        // Output saturation: strong sources at tiny distance, several kept
        for (int i = 0; i < 4; i++)
        begin
            s = '{32'd300, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 31'd0, i == 3};
            send_source(s);
        end
        for (int i = 0; i < 3; i++)
        begin
            s = '{32'd0, 32'd300, 32'd0, 32'd0, 32'h8000_0000, 31'd0, i == 2};
            send_source(s);
        end
        // Sums kept across sources that are not last
        for (int i = 0; i < 3; i++)
            send_source(rand_source(32'h0001_0000, 32'hFFFF_0000, i == 2));
    endtask

    initial
    begin
        board = new();
        board.clear_sums();
        board.min_dist = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        n_sources = 0;
        timed_out = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        run_directed();
        drain_results();

        // Random phases across idling patterns and thresholds
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (ph)
                0: set_min_dist(16'd0);
                3: set_min_dist(16'hFFFF);
                5: set_min_dist(16'(1 << $urandom_range(15)));
                6: set_min_dist(16'($urandom));
                default: ;
            endcase
            for (int t = 0; t < 28; t++)
                send_target();
            drain_results();
        end

        $display("Sent %0d sources and checked %0d velocity results over four",
                 n_sources, board.n_checked);
        $display("handshake pressure patterns and several distance thresholds.");
        if (board.n_errors == 0 && board.pending_vel.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/vvds_pkg.sv
rtl/core/vvds_div.sv
rtl/core/vvds_datapath.sv
rtl/core/vvds_ctrl.sv
rtl/core/vortex_velocity_direct_sum_top.sv
tb/tb_vortex_velocity_direct_sum_top.sv
